FILE: rtl/sm3_pkg.sv
package sm3_pkg;

    // SM3 round constants, before rotation
    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;

    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned DIGEST_WORDS = 8;

    typedef logic [7:0][31:0]  sm3_words8_t;
    typedef logic [15:0][31:0] sm3_words16_t;

    // Standard initial chaining value, word 0 in the lowest slot
    localparam sm3_words8_t SM3_IV = {
        32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
        32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
    };

    // One queued message word with its flags
    typedef struct packed {
        logic [31:0] msg_word;
        logic        new_message;
        logic        message_end;
    } sm3_item_t;

    // Commands from the sequencer to the compression unit
    typedef struct packed {
        logic load_word;
        logic load_iv;
        logic start;
    } sm3_ctl_t;

    // Status from the compression unit
    typedef struct packed {
        logic busy;
        logic done;
    } sm3_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPRESS,
        ST_EMIT
    } sm3_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    // Round constant rotated by the round number
    function automatic logic [31:0] round_const(input logic [5:0] rnd);
        logic [31:0] base;
        base = (rnd[5:4] == 2'b00) ? T_LOW : T_HIGH;
        return rotl(base, rnd[4:0]);
    endfunction

endpackage

FILE: rtl/sm3_fifo.sv
module sm3_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sm3_pkg::sm3_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output sm3_pkg::sm3_item_t  pop_item,
    output logic                not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sm3_pkg::sm3_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming transfer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/sm3_compress.sv
module sm3_compress (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sm3_pkg::sm3_ctl_t     ctl,
    input  logic [31:0]           word,
    output sm3_pkg::sm3_stat_t    stat,
    output sm3_pkg::sm3_words8_t  chain
);

    localparam logic [5:0] LAST_ROUND = 6'(sm3_pkg::ROUNDS - 1);

    sm3_pkg::sm3_words16_t win_reg, win_next;
    sm3_pkg::sm3_words8_t  work_reg, work_next;
    sm3_pkg::sm3_words8_t  chain_reg, chain_next;
    logic [5:0]            round_reg, round_next;
    logic                  busy_reg, busy_next;

    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] w_new, a12, ss1, ss2, ffv, ggv, tt1, tt2;
    logic        early;

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (round_reg == LAST_ROUND);
    assign chain     = chain_reg;

    // One compression round and the next expanded word
    always_comb
    begin
        a = work_reg[0]; b = work_reg[1]; c = work_reg[2]; d = work_reg[3];
        e = work_reg[4]; f = work_reg[5]; g = work_reg[6]; h = work_reg[7];
        early = (round_reg[5:4] == 2'b00);

        w_new = sm3_pkg::perm1(win_reg[0] ^ win_reg[7] ^ sm3_pkg::rotl(win_reg[13], 5'd15))
                ^ sm3_pkg::rotl(win_reg[3], 5'd7) ^ win_reg[10];

        a12 = sm3_pkg::rotl(a, 5'd12);
        ss1 = sm3_pkg::rotl(a12 + e + sm3_pkg::round_const(round_reg), 5'd7);
        ss2 = ss1 ^ a12;
        ffv = early ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
        ggv = early ? (e ^ f ^ g) : ((e & f) | (~e & g));
        tt1 = ffv + d + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = ggv + h + ss1 + win_reg[0];
    end

    // Sequence loads, rounds and the chaining update
    always_comb
    begin
        win_next   = win_reg;
        work_next  = work_reg;
        chain_next = chain_reg;
        round_next = round_reg;
        busy_next  = busy_reg;

        if (busy_reg)
        begin
            win_next   = {w_new, win_reg[15:1]};
            work_next  = {g, sm3_pkg::rotl(f, 5'd19), e, sm3_pkg::perm0(tt2),
                          c, sm3_pkg::rotl(b, 5'd9), a, tt1};
            round_next = round_reg + 1'b1;
            if (round_reg == LAST_ROUND)
            begin
                chain_next = chain_reg ^ work_next;
                busy_next  = 1'b0;
                round_next = '0;
            end
        end
        else
        begin
            if (ctl.load_iv)
            begin
                chain_next = sm3_pkg::SM3_IV;
            end
            if (ctl.load_word)
            begin
                win_next = {word, win_reg[15:1]};
            end
            if (ctl.start)
            begin
                work_next  = chain_reg;
                busy_next  = 1'b1;
                round_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= sm3_pkg::SM3_IV;
            round_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            chain_reg <= chain_next;
            round_reg <= round_next;
            busy_reg  <= busy_next;
        end
    end

    // Hold the window and working variables
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

endmodule

FILE: rtl/sm3_hash_engine.sv
// SM3 hash engine over an already padded message.
// Input stream (s_*): one 32-bit big-endian message word per transfer in
// s_tdata; s_tuser marks the first word of a message (the chaining value is
// reloaded with the standard IV), s_tlast marks the last word of the message.
// Output stream (m_*): eight digest words per message, word 0 first, with
// the word position in m_tuser and m_tlast on the eighth word.
// Words enter a small queue and are taken by the sequencer one per cycle
// while it is idle, not during a compression or digest output. The sixteenth
// word of a block starts the compression unit, which runs one round per
// cycle over the 64 rounds of a block. The queue keeps accepting while the
// unit is busy until it is full.
// After the final word leaves the queue the first digest word appears in
// the next cycle, or after the compression when that word ends a block.
// Message end inside a block drops the partial block.
// Reset loads the IV, empties the queue and clears the word count.
// When the receiver stalls, the current digest word holds on m_tdata and the
// sequencer waits; the queue fills and then s_tready drops.
module sm3_hash_engine #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] msg_word
    input  logic        s_tuser,   // [0] new_message
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] digest_index
    output logic        m_tlast
);

    sm3_pkg::sm3_item_t   in_item, q_item;
    sm3_pkg::sm3_ctl_t    ctl;
    sm3_pkg::sm3_stat_t   stat;
    sm3_pkg::sm3_words8_t chain;
    sm3_pkg::sm3_state_t  state_reg, state_next;

    logic       q_full, q_valid, pop;
    logic [3:0] wc_reg, wc_next, wc_eff;
    logic [2:0] idx_reg, idx_next;
    logic       end_reg, end_next;

    assign in_item.msg_word    = s_tdata;
    assign in_item.new_message = s_tuser;
    assign in_item.message_end = s_tlast;
    assign s_tready = !q_full;

    sm3_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_item (in_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (q_item),
        .not_empty (q_valid)
    );

    sm3_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .word  (q_item.msg_word),
        .stat  (stat),
        .chain (chain)
    );

    assign wc_eff = q_item.new_message ? 4'd0 : wc_reg;

    // Drive the digest from the chaining value
    assign m_tvalid = (state_reg == sm3_pkg::ST_EMIT);
    assign m_tdata  = chain[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == 3'(sm3_pkg::DIGEST_WORDS - 1));

    // Sequence words, compressions and digest output
    always_comb
    begin
        state_next    = state_reg;
        wc_next       = wc_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        pop           = 1'b0;
        ctl.load_word = 1'b0;
        ctl.load_iv   = 1'b0;
        ctl.start     = 1'b0;

        case (state_reg)
            sm3_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop           = 1'b1;
                    ctl.load_word = 1'b1;
                    ctl.load_iv   = q_item.new_message;
                    wc_next       = wc_eff + 1'b1;
                    if (wc_eff == 4'(sm3_pkg::BLOCK_WORDS - 1))
                    begin
                        ctl.start  = 1'b1;
                        end_next   = q_item.message_end;
                        state_next = sm3_pkg::ST_COMPRESS;
                    end
                    else if (q_item.message_end)
                    begin
                        wc_next    = '0;
                        state_next = sm3_pkg::ST_EMIT;
                    end
                end
            end
            sm3_pkg::ST_COMPRESS:
            begin
                if (stat.done)
                begin
                    state_next = end_reg ? sm3_pkg::ST_EMIT : sm3_pkg::ST_IDLE;
                end
            end
            sm3_pkg::ST_EMIT:
            begin
                if (m_tready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (m_tlast)
                    begin
                        idx_next   = '0;
                        state_next = sm3_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sm3_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sm3_pkg::ST_IDLE;
            wc_reg    <= '0;
            idx_reg   <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wc_reg    <= wc_next;
            idx_reg   <= idx_next;
            end_reg   <= end_next;
        end
    end

    // No word is taken while a block is being compressed
    assert property (@(posedge clk) disable iff (!rst_n) stat.busy |-> !pop)
        else $error("word taken during compression");

    // Digest words go out in order
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("digest index out of sequence");

    // Output closes after the eighth word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("digest output not closed after last word");

    // Compression starts only with an idle unit
    assert property (@(posedge clk) disable iff (!rst_n) ctl.start |-> !stat.busy)
        else $error("compression started while busy");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // SM3 round constants and initial chaining value
    localparam logic [31:0] TJ_EARLY = 32'h79cc4519;
    localparam logic [31:0] TJ_LATE  = 32'h7a879d8a;
    localparam logic [31:0] SM3_INIT [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] msg_word
    logic        s_tuser;   // [0] new_message
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] digest_word
    logic [2:0]  m_tuser;   // [2:0] digest_index
    logic        m_tlast;

    // Hash state mirrored by the testbench
    logic [31:0] chain_val [8];
    logic [31:0] block_buf [16];
    logic [3:0]  words_held;

    digest_beat_t expected_digest [$];

    int errors;
    int words_sent;
    int digests_due;
    int blocks_hashed;
    int beats_checked;
    int input_stall_cycles;
    int tx_gap_max;
    int rx_gap_max;
    int rx_hold_request;

    sm3_hash_engine DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned n);
        int unsigned s;
        s = n % 32;
        if (s == 0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] p0_mix(input logic [31:0] x);
        return x ^ rot_left(x, 9) ^ rot_left(x, 17);
    endfunction

    function automatic logic [31:0] p1_mix(input logic [31:0] x);
        return x ^ rot_left(x, 15) ^ rot_left(x, 23);
    endfunction

    // Expand the held block and run the 64 rounds into the chaining value
    function automatic void compress_held_block();
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
        int j;
        for (j = 0; j < 16; j++)
            w[j] = block_buf[j];
        for (j = 16; j < 68; j++)
            w[j] = p1_mix(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15))
                   ^ rot_left(w[j-13], 7) ^ w[j-6];
        a = chain_val[0]; b = chain_val[1]; c = chain_val[2]; d = chain_val[3];
        e = chain_val[4]; f = chain_val[5]; g = chain_val[6]; h = chain_val[7];
        for (j = 0; j < 64; j++)
        begin
            tj  = rot_left((j < 16) ? TJ_EARLY : TJ_LATE, j);
            a12 = rot_left(a, 12);
            ss1 = rot_left(a12 + e + tj, 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ffv = a ^ b ^ c;
                ggv = e ^ f ^ g;
            end
            else
            begin
                ffv = (a & b) | (a & c) | (b & c);
                ggv = (e & f) | (~e & g);
            end
            tt1 = ffv + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = ggv + h + ss1 + w[j];
            d = c; c = rot_left(b, 9); b = a; a = tt1;
            h = g; g = rot_left(f, 19); f = e; e = p0_mix(tt2);
        end
        chain_val[0] ^= a; chain_val[1] ^= b; chain_val[2] ^= c; chain_val[3] ^= d;
        chain_val[4] ^= e; chain_val[5] ^= f; chain_val[6] ^= g; chain_val[7] ^= h;
    endfunction

    // Take one accepted word; queue the eight digest words on message end
    function automatic void absorb_word(input logic [31:0] word, input logic first,
                                        input logic last);
        digest_beat_t beat;
        int k;
        if (first)
        begin
            for (k = 0; k < 8; k++)
                chain_val[k] = SM3_INIT[k];
            words_held = '0;
        end
        block_buf[words_held] = word;
        words_held = words_held + 4'd1;
        if (words_held == 4'd0)
        begin
            compress_held_block();
            blocks_hashed++;
        end
        if (last)
        begin
            // a partial block is dropped; the digest is the chaining value as is
            words_held = '0;
            digests_due++;
            for (k = 0; k < 8; k++)
            begin
                beat.word  = chain_val[k];
                beat.index = k[2:0];
                beat.last  = (k == 7);
                expected_digest.push_back(beat);
            end
        end
    endfunction

    // Mostly random words, with the all-zero and all-one extremes mixed in
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Offer one word after a random gap and hold it until the transfer
    task automatic send_word(input logic [31:0] word, input logic first, input logic last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= first;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        absorb_word(word, first, last);
        words_sent++;
    endtask

    // Receiver: random stall per digest word, or a long hold on request
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_request > 0)
            begin
                stall = rx_hold_request;
                rx_hold_request = 0;
            end
            else
                stall = $urandom_range(0, rx_gap_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Compare each digest transfer against the oldest expectation and count input stall cycles
    initial
    begin
        digest_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && s_tvalid && !s_tready)
                input_stall_cycles++;
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_digest.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected digest word %h idx %0d last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = expected_digest.pop_front();
                    beats_checked++;
                    if (m_tdata !== want.word || m_tuser !== want.index
                        || m_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 $time, want.word, want.index, want.last,
                                 m_tdata, m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    // Standard one-block vector "abc", no idling on either side
    task automatic test_known_vector();
        int j;
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_word(32'h6162_6380, 1'b1, 1'b0);
        for (j = 1; j < 15; j++)
            send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'h0000_0018, 1'b0, 1'b1);
    endtask

    // Chaining after an end, start and end on one word, and a dropped partial block
    task automatic test_message_edges();
        tx_gap_max = 19;
        rx_gap_max = 19;
        send_word(32'hffff_ffff, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        send_word(32'hffff_ffff, 1'b1, 1'b1);
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(32'hffff_ffff, 1'b0, 1'b0);
        send_word(32'h8000_0001, 1'b0, 1'b1);
    endtask

    // Hold the receiver off while full blocks keep arriving back to back
    task automatic test_back_pressure();
        int j;
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_request = 400;
        send_word(pick_word(), 1'b1, 1'b1);
        for (j = 0; j < 32; j++)
            send_word(pick_word(), j == 0, j == 31);
    endtask

    // Mostly well-formed messages with random content, some partial and noisy ones
    task automatic test_random_traffic();
        int kind, nblk, len, pre, j, sent;
        logic first_flag;
        sent = 0;
        while (sent < 270)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end
            else
            begin
                tx_gap_max = 19;
                rx_gap_max = 19;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                nblk = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(1, 2);
                first_flag = ($urandom_range(0, 3) != 0);
                len = nblk * 16;
                for (j = 0; j < len; j++)
                    send_word(pick_word(), (j == 0) && first_flag, j == len - 1);
            end
            else if (kind <= 7)
            begin
                len = $urandom_range(1, 15);
                for (j = 0; j < len; j++)
                    send_word(pick_word(), j == 0, j == len - 1);
            end
            else if (kind == 8)
            begin
                len = $urandom_range(1, 20);
                for (j = 0; j < len; j++)
                    send_word(pick_word(), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 7) == 0);
            end
            else
            begin
                // restart a message part way through a block
                pre = $urandom_range(1, 15);
                for (j = 0; j < pre; j++)
                    send_word(pick_word(), j == 0, 1'b0);
                for (j = 0; j < 16; j++)
                    send_word(pick_word(), j == 0, j == 15);
                len = pre + 16;
            end
            sent += len;
        end
    endtask

    initial
    begin
        int k;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        errors = 0;
        words_sent = 0;
        digests_due = 0;
        blocks_hashed = 0;
        beats_checked = 0;
        input_stall_cycles = 0;
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_request = 0;
        for (k = 0; k < 8; k++)
            chain_val[k] = SM3_INIT[k];
        words_held = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_known_vector();
        test_message_edges();
        test_back_pressure();
        test_random_traffic();
        s_tvalid <= 1'b0;

        // drain outstanding digests, then watch for stray output
        while (expected_digest.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("Covered %0d message words, %0d full blocks hashed, %0d digests.",
                 words_sent, blocks_hashed, digests_due);
        $display("Checked %0d digest words; input held off for %0d cycles.",
                 beats_checked, input_stall_cycles);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d digest words still expected.", expected_digest.size());
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
